FILE: rtl/pcul_pkg.sv
// ----------------------------------------------------------------------------
// pcul_pkg
// Shared types and constants for the polyline off-screen point culler.
// ----------------------------------------------------------------------------
package pcul_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIM_BITS   = 15;
  // common width for comparing a non-negative coordinate against a surface size
  localparam int CMP_BITS   = (COORD_BITS - 1 > DIM_BITS) ? COORD_BITS - 1 : DIM_BITS;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

  typedef enum logic [0:0] {
    CFG_SURFACE_WIDTH  = 1'b0,
    CFG_SURFACE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    REG_ON_SCREEN   = 4'd0,
    REG_LEFT        = 4'd1,
    REG_UPPER_LEFT  = 4'd2,
    REG_TOP         = 4'd3,
    REG_UPPER_RIGHT = 4'd4,
    REG_RIGHT       = 4'd5,
    REG_LOWER_RIGHT = 4'd6,
    REG_BOTTOM      = 4'd7,
    REG_LOWER_LEFT  = 4'd8
  } region_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] in_x;
    logic signed [COORD_BITS-1:0] in_y;
    logic                         line_start;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         out_last;
  } out_item_t;

  // up to two result items written into the output queue in one cycle
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

FILE: rtl/pcul_region.sv
// ----------------------------------------------------------------------------
// pcul_region
// Sorts a vertex into the visible surface or one of eight outside regions.
// ----------------------------------------------------------------------------
module pcul_region (
  input  logic signed [pcul_pkg::COORD_BITS-1:0] x,
  input  logic signed [pcul_pkg::COORD_BITS-1:0] y,
  input  logic [pcul_pkg::DIM_BITS-1:0]          width,
  input  logic [pcul_pkg::DIM_BITS-1:0]          height,
  output pcul_pkg::region_t                      region
);

  logic                          x_lo;
  logic                          x_hi;
  logic                          y_lo;
  logic                          y_hi;
  logic [pcul_pkg::CMP_BITS-1:0] x_mag;
  logic [pcul_pkg::CMP_BITS-1:0] y_mag;
  logic [pcul_pkg::CMP_BITS-1:0] w_ext;
  logic [pcul_pkg::CMP_BITS-1:0] h_ext;

  assign x_lo  = x[pcul_pkg::COORD_BITS-1];
  assign y_lo  = y[pcul_pkg::COORD_BITS-1];
  assign x_mag = pcul_pkg::CMP_BITS'(x[pcul_pkg::COORD_BITS-2:0]);
  assign y_mag = pcul_pkg::CMP_BITS'(y[pcul_pkg::COORD_BITS-2:0]);
  assign w_ext = pcul_pkg::CMP_BITS'(width);
  assign h_ext = pcul_pkg::CMP_BITS'(height);
  // negative values never reach the far edge
  assign x_hi  = !x_lo && (x_mag >= w_ext);
  assign y_hi  = !y_lo && (y_mag >= h_ext);

  always_comb begin
    if (x_lo) begin
      region = y_lo ? pcul_pkg::REG_UPPER_LEFT
             : (y_hi ? pcul_pkg::REG_LOWER_LEFT : pcul_pkg::REG_LEFT);
    end else if (x_hi) begin
      region = y_lo ? pcul_pkg::REG_UPPER_RIGHT
             : (y_hi ? pcul_pkg::REG_LOWER_RIGHT : pcul_pkg::REG_RIGHT);
    end else begin
      region = y_lo ? pcul_pkg::REG_TOP
             : (y_hi ? pcul_pkg::REG_BOTTOM : pcul_pkg::REG_ON_SCREEN);
    end
  end

endmodule

FILE: rtl/pcul_out_fifo.sv
// ----------------------------------------------------------------------------
// pcul_out_fifo
// Small result queue: takes up to two items per cycle, hands out one while out_ready is high.
// ----------------------------------------------------------------------------
module pcul_out_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcul_pkg::push_t               push,
  output logic                          room_for_two,
  output logic [pcul_pkg::FIFO_CW-1:0]  level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pcul_pkg::out_item_t           out_data
);

  pcul_pkg::out_item_t          mem [pcul_pkg::FIFO_DEPTH];
  logic [pcul_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [pcul_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [pcul_pkg::FIFO_CW-1:0] count_r, count_nxt;
  logic [pcul_pkg::FIFO_AW-1:0] wr_ptr_p1;
  logic                         pop;

  assign wr_ptr_p1    = wr_ptr_r + pcul_pkg::FIFO_AW'(1);
  assign pop          = out_valid && out_ready;
  assign out_valid    = (count_r != '0);
  assign out_data     = mem[rd_ptr_r];
  assign level        = count_r;
  assign room_for_two = (count_r <= pcul_pkg::FIFO_CW'(pcul_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + pcul_pkg::FIFO_AW'(push.count);
    rd_ptr_nxt = pop ? rd_ptr_r + pcul_pkg::FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + pcul_pkg::FIFO_CW'(push.count) - pcul_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_p1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/polyline_offscreen_point_culler.sv
// ----------------------------------------------------------------------------
// polyline_offscreen_point_culler
// Drops polyline vertices that stay in one outside region, re-emits the
// last dropped vertex on re-entry and suppresses exact repeats.
// ----------------------------------------------------------------------------
// results are registered: each accepted vertex's results are written into the result queue and leave from there
// throughput: one vertex per cycle while the result queue has room for two items; a re-entry
//   yields two results, and the result port is one item wide
// input is taken while the four-entry result queue has room for two items
// reset (synchronous, rst_n low): queue empty, previous vertex (0,0) on
//   screen, no pending drop, surface 640 x 480
module polyline_offscreen_point_culler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pcul_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pcul_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [pcul_pkg::DIM_BITS-1:0]       cfg_wdata
);

  logic [pcul_pkg::DIM_BITS-1:0]          width_r;
  logic [pcul_pkg::DIM_BITS-1:0]          height_r;
  logic signed [pcul_pkg::COORD_BITS-1:0] prev_x_r, prev_x_nxt;
  logic signed [pcul_pkg::COORD_BITS-1:0] prev_y_r, prev_y_nxt;
  pcul_pkg::region_t                      prev_region_r, prev_region_nxt;
  logic                                   dropped_pending_r, dropped_pending_nxt;

  pcul_pkg::region_t              region;
  pcul_pkg::push_t                push;
  logic                           room_for_two;
  logic [pcul_pkg::FIFO_CW-1:0]   level;
  logic                           accept;
  logic                           same_outside;
  logic                           moved;
  pcul_pkg::out_item_t            cur_item;
  pcul_pkg::out_item_t            prev_item;

  assign in_ready = room_for_two;
  assign accept   = in_valid && in_ready;

  pcul_region u_region (
    .x      (in_data.in_x),
    .y      (in_data.in_y),
    .width  (width_r),
    .height (height_r),
    .region (region)
  );

  assign same_outside = (prev_region_r != pcul_pkg::REG_ON_SCREEN) && (region == prev_region_r);
  assign moved        = (in_data.in_x != prev_x_r) || (in_data.in_y != prev_y_r);

  always_comb begin
    cur_item.out_x     = in_data.in_x;
    cur_item.out_y     = in_data.in_y;
    cur_item.out_last  = 1'b1;
    prev_item.out_x    = prev_x_r;
    prev_item.out_y    = prev_y_r;
    prev_item.out_last = 1'b0;

    push.count          = 2'd0;
    push.first          = cur_item;
    push.second         = cur_item;
    prev_x_nxt          = prev_x_r;
    prev_y_nxt          = prev_y_r;
    prev_region_nxt     = prev_region_r;
    dropped_pending_nxt = dropped_pending_r;

    if (accept) begin
      prev_x_nxt      = in_data.in_x;
      prev_y_nxt      = in_data.in_y;
      prev_region_nxt = region;
      if (in_data.line_start) begin
        push.count          = 2'd1;
        dropped_pending_nxt = 1'b0;
      end else if (same_outside) begin
        dropped_pending_nxt = 1'b1;
      end else begin
        dropped_pending_nxt = 1'b0;
        if (moved) begin
          if (dropped_pending_r) begin
            // re-entry: the last dropped vertex goes out ahead of this one
            push.count = 2'd2;
            push.first = prev_item;
          end else begin
            push.count = 2'd1;
          end
        end
      end
    end
  end

  pcul_out_fifo u_out_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .room_for_two (room_for_two),
    .level        (level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= pcul_pkg::WIDTH_RESET;
      height_r <= pcul_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pcul_pkg::CFG_SURFACE_WIDTH:  width_r  <= cfg_wdata;
        pcul_pkg::CFG_SURFACE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r          <= '0;
      prev_y_r          <= '0;
      prev_region_r     <= pcul_pkg::REG_ON_SCREEN;
      dropped_pending_r <= 1'b0;
    end else begin
      prev_x_r          <= prev_x_nxt;
      prev_y_r          <= prev_y_nxt;
      prev_region_r     <= prev_region_nxt;
      dropped_pending_r <= dropped_pending_nxt;
    end
  end

  // queue never overfills
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= pcul_pkg::FIFO_CW'(pcul_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // a line start clears any pending drop
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.line_start |=> !dropped_pending_r)
    else $error("pending drop survived a line start");

  // a two-result re-entry only happens after a drop
  a_pair_needs_drop: assert property (@(posedge clk) disable iff (!rst_n)
    push.count == 2'd2 |-> dropped_pending_r && accept)
    else $error("re-emit without a pending drop");

  // the previous vertex tracks every accepted item
  a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> prev_x_r == $past(in_data.in_x) && prev_y_r == $past(in_data.in_y))
    else $error("previous vertex not updated");

endmodule

FILE: tb/polyline_offscreen_point_culler_tb.sv
// ----------------------------------------------------------------------------
// polyline_offscreen_point_culler_tb
// Self-checking bench for the off-screen point culler. A scoreboard class
// tracks the previous vertex, its region and the pending drop, and predicts
// the emitted vertices of every accepted item. Directed vertices cover the
// region edges, coordinate extremes, drops, re-entries, repeats and line
// starts. Random polylines then walk across region borders under several
// surface sizes, with noise vertices, random stalls on both channels, one long
// result stall and drain pauses between phases.
// ----------------------------------------------------------------------------
module polyline_offscreen_point_culler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcul_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_STALL     = 80;
  localparam int SETTLE_CYCLES  = 4;

  class cull_scoreboard;
    logic [DIM_BITS-1:0]          width;
    logic [DIM_BITS-1:0]          height;
    logic signed [COORD_BITS-1:0] last_x;
    logic signed [COORD_BITS-1:0] last_y;
    region_t                      last_region;
    bit                           drop_pending;
    out_item_t                    awaited_vertices[$];
    int                           error_count;

    function new();
      width        = WIDTH_RESET;
      height       = HEIGHT_RESET;
      last_x       = '0;
      last_y       = '0;
      last_region  = REG_ON_SCREEN;
      drop_pending = 1'b0;
      error_count  = 0;
    endfunction

    function void set_surface(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
      width  = w;
      height = h;
    endfunction

    function region_t classify(logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y);
      int xi;
      int yi;
      bit xl;
      bit xh;
      bit yl;
      bit yh;
      xi = x;
      yi = y;
      xl = xi < 0;
      xh = xi >= int'(width);
      yl = yi < 0;
      yh = yi >= int'(height);
      if (xl) return yl ? REG_UPPER_LEFT : (yh ? REG_LOWER_LEFT : REG_LEFT);
      if (xh) return yl ? REG_UPPER_RIGHT : (yh ? REG_LOWER_RIGHT : REG_RIGHT);
      return yl ? REG_TOP : (yh ? REG_BOTTOM : REG_ON_SCREEN);
    endfunction

    function void await_vertex(logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y, logic last);
      out_item_t e;
      e.out_x    = x;
      e.out_y    = y;
      e.out_last = last;
      awaited_vertices.push_back(e);
    endfunction

    function void note_vertex(in_item_t v);
      region_t r;
      r = classify(v.in_x, v.in_y);
      if (v.line_start) begin
        await_vertex(v.in_x, v.in_y, 1'b1);
        drop_pending = 1'b0;
      end else if (last_region != REG_ON_SCREEN && r == last_region) begin
        drop_pending = 1'b1;
      end else begin
        if (v.in_x != last_x || v.in_y != last_y) begin
          // re-entry: the last dropped vertex goes out first
          if (drop_pending) await_vertex(last_x, last_y, 1'b0);
          await_vertex(v.in_x, v.in_y, 1'b1);
        end
        drop_pending = 1'b0;
      end
      last_x      = v.in_x;
      last_y      = v.in_y;
      last_region = r;
    endfunction

    function void check_emitted(out_item_t got);
      out_item_t want;
      if (awaited_vertices.size() == 0) begin
        $display("%0t unexpected item: expected none, actual x %0d y %0d last %0b",
                 $time, got.out_x, got.out_y, got.out_last);
        error_count++;
        return;
      end
      want = awaited_vertices.pop_front();
      if (got.out_x !== want.out_x) begin
        $display("%0t out_x mismatch: expected %0d, actual %0d",
                 $time, want.out_x, got.out_x);
        error_count++;
      end
      if (got.out_y !== want.out_y) begin
        $display("%0t out_y mismatch: expected %0d, actual %0d",
                 $time, want.out_y, got.out_y);
        error_count++;
      end
      if (got.out_last !== want.out_last) begin
        $display("%0t out_last mismatch: expected %0b, actual %0b",
                 $time, want.out_last, got.out_last);
        error_count++;
      end
    endfunction

    function int pending();
      return awaited_vertices.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_we;
  logic [0:0]          cfg_index;
  logic [DIM_BITS-1:0] cfg_wdata;

  cull_scoreboard sb;
  bit             in_gaps       = 1'b1;
  bit             out_gaps      = 1'b1;
  bit             stall_request = 1'b0;
  int             cur_w         = 640;
  int             cur_h         = 480;
  int unsigned    idle_cycles   = 0;

  polyline_offscreen_point_culler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // results are checked before the new item is noted; latency keeps them apart
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_emitted(out_data);
      if (in_valid && in_ready) sb.note_vertex(in_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no item moved for %0d cycles", $time, idle_cycles);
      $display("polyline_offscreen_point_culler verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_sink
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_request) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_request = 1'b0;
      end else if (out_gaps && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic offer_vertex(input int x, input int y, input bit start);
    in_item_t v;
    v.in_x       = COORD_BITS'(x);
    v.in_y       = COORD_BITS'(y);
    v.line_start = start;
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // a vertex with no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_surface(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SURFACE_WIDTH;
    cfg_wdata <= DIM_BITS'(w);
    @(posedge clk);
    cfg_index <= CFG_SURFACE_HEIGHT;
    cfg_wdata <= DIM_BITS'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = w;
    cur_h = h;
    sb.set_surface(DIM_BITS'(w), DIM_BITS'(h));
  endtask

  // polylines wandering across region borders, with repeats and noise
  task automatic run_walks(input int count);
    int                           cx;
    int                           cy;
    int                           pick;
    int                           span;
    int                           s;
    logic signed [COORD_BITS-1:0] r16;
    cx = 0;
    cy = 0;
    span = ((cur_w > cur_h) ? cur_w : cur_h) / 3 + 2;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (i == 0 || pick < 8) begin
        cx = clamp_coord(int'($urandom_range(0, 2 * cur_w + 64)) - cur_w / 2 - 32);
        cy = clamp_coord(int'($urandom_range(0, 2 * cur_h + 64)) - cur_h / 2 - 32);
        offer_vertex(cx, cy, 1'b1);
      end else if (pick < 16) begin
        offer_vertex(cx, cy, 1'b0);
      end else if (pick < 24) begin
        r16 = COORD_BITS'($urandom);
        cx = r16;
        r16 = COORD_BITS'($urandom);
        cy = r16;
        offer_vertex(cx, cy, 1'($urandom_range(0, 1)));
      end else begin
        s = $urandom_range(0, 1) ? int'($urandom_range(1, 4)) : span;
        cx = clamp_coord(cx + int'($urandom_range(0, 2 * s)) - s);
        s = $urandom_range(0, 1) ? int'($urandom_range(1, 4)) : span;
        cy = clamp_coord(cy + int'($urandom_range(0, 2 * s)) - s);
        offer_vertex(cx, cy, 1'b0);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_SURFACE_WIDTH;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset surface 640 x 480
    offer_vertex(0, 0, 1'b0);            // repeat of the reset vertex
    offer_vertex(0, 0, 1'b1);
    offer_vertex(-5, 100, 1'b0);
    offer_vertex(-10, 200, 1'b0);        // dropped
    offer_vertex(-20, 300, 1'b0);        // dropped
    offer_vertex(100, 100, 1'b0);        // re-entry
    offer_vertex(100, 100, 1'b0);        // repeat
    offer_vertex(-32768, -32768, 1'b0);
    offer_vertex(-32768, -32767, 1'b0);
    offer_vertex(32767, 32767, 1'b1);    // line start discards the drop
    offer_vertex(32767, -32768, 1'b0);
    offer_vertex(639, 479, 1'b0);
    offer_vertex(640, 479, 1'b0);
    offer_vertex(640, 100, 1'b0);
    offer_vertex(640, 100, 1'b0);        // same outside vertex again
    offer_vertex(100, -1, 1'b0);
    offer_vertex(0, 480, 1'b0);
    offer_vertex(-1, 480, 1'b0);
    offer_vertex(-1, 0, 1'b0);
    offer_vertex(0, -1, 1'b0);
    offer_vertex(-1, -1, 1'b0);
    offer_vertex(-2, -2, 1'b0);
    offer_vertex(-3, -3, 1'b1);
    offer_vertex(32767, 0, 1'b0);
    offer_vertex(32000, 5, 1'b0);        // drop left pending over the resize
    wait_drained();

    // a wider surface puts the pending vertex on screen: the repeat is suppressed
    write_surface(32767, 480);
    offer_vertex(32000, 5, 1'b0);
    wait_drained();

    write_surface(1, 1);
    run_walks(250);
    wait_drained();

    write_surface(32767, 32767);
    run_walks(120);
    stall_request = 1'b1;
    run_walks(130);
    wait_drained();

    write_surface(0, 0);
    run_walks(150);
    wait_drained();

    write_surface($urandom_range(1, 200), $urandom_range(1, 200));
    run_walks(150);
    wait_drained();
    run_walks(150);
    wait_drained();

    write_surface(32767, 1);
    run_walks(150);
    wait_drained();

    write_surface($urandom_range(1, 32767), $urandom_range(1, 32767));
    run_walks(300);
    wait_drained();

    write_surface(640, 480);
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    run_walks(400);
    wait_drained();
    repeat (8) @(posedge clk);

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("polyline_offscreen_point_culler verification clean");
    end else begin
      $display("polyline_offscreen_point_culler verification failed");
    end
    $finish;
  end

endmodule
